[hdl/plcm_pkg.sv]
`default_nettype none
package plcm_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 4;
    localparam int IN_W        = 32;
    localparam int VALUE_W     = 32;
    localparam int COLOR_W     = 24;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int PROD_W      = VALUE_W + CH_W;
    localparam int DIV_STEPS   = CH_W;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES = 2'd0,
        CFG_BOUNDED = 2'd1,
        CFG_BELOW   = 2'd2,
        CFG_ABOVE   = 2'd3
    } cfg_idx_t;

    // Input item as held in the entry register.
    typedef struct packed {
        action_t             action;
        logic [IDX_W-1:0]    entry_index;
        logic [VALUE_W-1:0]  entry_value;
        logic [COLOR_W-1:0]  entry_color;
        logic [VALUE_W-1:0]  sample_value;
    } plcm_item_t;

    // Result of the table search.
    typedef struct packed {
        logic                direct;
        logic [COLOR_W-1:0]  dcolor;
        logic                below;
        logic                above;
        logic [VALUE_W-1:0]  dv;
        logic [VALUE_W-1:0]  span;
        logic [COLOR_W-1:0]  cp;
        logic [COLOR_W-1:0]  cc;
    } plcm_lk_t;

    // Per-item state carried through the division stages.
    typedef struct packed {
        logic                          direct;
        logic [COLOR_W-1:0]            dcolor;
        logic                          below;
        logic                          above;
        logic [VALUE_W-1:0]            span;
        logic [NUM_CH-1:0][CH_W-1:0]   p;
        logic [NUM_CH-1:0]             neg;
        logic [NUM_CH-1:0][PROD_W-1:0] rem;
        logic [NUM_CH-1:0][CH_W-1:0]   q;
    } plcm_div_t;

    // One restoring division step producing quotient bit k of every channel.
    function automatic plcm_div_t plcm_div_step(plcm_div_t x, int k);
        plcm_div_t         y;
        logic [PROD_W-1:0] d;
        y = x;
        d = {{CH_W{1'b0}}, x.span} << k;
        for (int c = 0; c < NUM_CH; c++) begin
            if (x.rem[c] >= d) begin
                y.rem[c]  = x.rem[c] - d;
                y.q[c][k] = 1'b1;
            end
        end
        return y;
    endfunction

endpackage
`default_nettype wire

[hdl/plcm_item_if.sv]
`default_nettype none
interface plcm_item_if;
    import plcm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [IDX_W-1:0]          entry_index;
    logic signed [IN_W-1:0]    entry_value;
    logic [COLOR_W-1:0]        entry_color;
    logic signed [IN_W-1:0]    sample_value;
    modport source (output valid, action, entry_index, entry_value, entry_color,
                    sample_value, input ready);
    modport sink (input valid, action, entry_index, entry_value, entry_color,
                  sample_value, output ready);
endinterface
`default_nettype wire

[hdl/plcm_result_if.sv]
`default_nettype none
interface plcm_result_if;
    import plcm_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color;
    logic               below_range;
    logic               above_range;
    modport source (output valid, color, below_range, above_range, input ready);
    modport sink (input valid, color, below_range, above_range, output ready);
endinterface
`default_nettype wire

[hdl/plcm_cfg_if.sv]
`default_nettype none
interface plcm_cfg_if;
    import plcm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/plcm_table.sv]
`default_nettype none
module plcm_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire plcm_pkg::plcm_item_t      in_item,
    input  wire logic [plcm_pkg::CNT_W-1:0]   entries_in_use,
    input  wire logic                      bounded_mode,
    input  wire logic [plcm_pkg::COLOR_W-1:0] below_color,
    input  wire logic [plcm_pkg::COLOR_W-1:0] above_color,
    output logic                           out_valid,
    output plcm_pkg::plcm_lk_t             out_lk
);
    import plcm_pkg::*;

    logic [VALUE_W-1:0] val_mem [MAX_ENTRIES];
    logic [COLOR_W-1:0] col_mem [MAX_ENTRIES];

    logic                   valid_reg;
    plcm_lk_t               lk_reg;
    plcm_lk_t               lk_next;
    logic [CNT_W-1:0]       n_sat;
    logic [IDX_W-1:0]       last;
    logic [MAX_ENTRIES-1:0] le;
    logic [MAX_ENTRIES-1:0] hit;
    logic [MAX_ENTRIES-1:0] last_sel;
    logic                   found;
    logic [VALUE_W-1:0]     v_cur;
    logic [VALUE_W-1:0]     v_prev;
    logic [COLOR_W-1:0]     c_cur;
    logic [COLOR_W-1:0]     c_prev;
    logic [COLOR_W-1:0]     c_last;
    logic                   le_last;
    logic signed [VALUE_W-1:0] s;

    // Table writes land in the same stage that searches the table, so items
    // see the table exactly in arrival order.
    always_ff @(posedge clk)
    begin
        if (en && in_valid && in_item.action == ACT_WRITE)
        begin
            val_mem[in_item.entry_index] <= in_item.entry_value;
            col_mem[in_item.entry_index] <= in_item.entry_color;
        end
    end

    always_comb
    begin
        s = signed'(in_item.sample_value);
        if (entries_in_use < CNT_W'(2))
            n_sat = CNT_W'(2);
        else if (entries_in_use > CNT_W'(MAX_ENTRIES))
            n_sat = CNT_W'(MAX_ENTRIES);
        else
            n_sat = entries_in_use;
        last = IDX_W'(n_sat - CNT_W'(1));

        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            le[i]       = s <= signed'(val_mem[i]);
            last_sel[i] = (IDX_W'(i) == last);
        end

        found = 1'b0;
        hit   = '0;
        for (int i = 1; i < MAX_ENTRIES; i++)
        begin
            if (!found && (CNT_W'(i) < n_sat) && le[i])
            begin
                hit[i] = 1'b1;
                found  = 1'b1;
            end
        end

        v_cur   = '0;
        v_prev  = '0;
        c_cur   = '0;
        c_prev  = '0;
        c_last  = '0;
        le_last = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (last_sel[i])
            begin
                c_last  = c_last | col_mem[i];
                le_last = le_last | le[i];
            end
            if (hit[i])
            begin
                v_cur = v_cur | val_mem[i];
                c_cur = c_cur | col_mem[i];
                if (i > 0)
                begin
                    v_prev = v_prev | val_mem[(i > 0) ? i - 1 : 0];
                    c_prev = c_prev | col_mem[(i > 0) ? i - 1 : 0];
                end
            end
        end

        lk_next.below = s < signed'(val_mem[0]);
        lk_next.above = !le_last;
        lk_next.dv    = VALUE_W'(s) - v_prev;
        lk_next.span  = v_cur - v_prev;
        lk_next.cp    = c_prev;
        lk_next.cc    = c_cur;
        lk_next.direct = 1'b1;
        priority if (bounded_mode && lk_next.below)
            lk_next.dcolor = below_color;
        else if (bounded_mode && lk_next.above)
            lk_next.dcolor = above_color;
        else if (le[0])
            lk_next.dcolor = col_mem[0];
        else if (!found)
            lk_next.dcolor = c_last;
        else
        begin
            lk_next.dcolor = c_last;
            lk_next.direct = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid && (in_item.action == ACT_LOOKUP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lk_reg <= lk_next;
    end

    assign out_valid = valid_reg;
    assign out_lk    = lk_reg;

endmodule
`default_nettype wire

[hdl/piecewise_linear_color_map.sv]
`default_nettype none
// Piecewise-linear color map.
//
// The item channel carries two kinds of request. A write request (action 0)
// loads one breakpoint entry, value and color, and yields no result. A lookup
// request (action 1) maps sample_value to a packed RGB color and yields one
// result with below_range and above_range flags. The cfg channel writes the
// four control registers by index; it is always ready and is meant to be used
// only while no request is in flight.
//
// The datapath is a 12-register pipeline: entry register, table search,
// channel multiply, eight restoring division steps (one quotient bit each)
// and the output register. One request is taken every cycle unless a
// finished result is stalled at the output.
//
// Reset clears all valid bits and the control registers (two entries in use,
// unbounded mode, black below and above colors). The table itself is not
// cleared and must be written before use.
//
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and item.ready drops, so nothing is lost or repeated.
module piecewise_linear_color_map (
    input wire logic  clk,
    input wire logic  rst_n,
    plcm_item_if.sink     item,
    plcm_result_if.source result,
    plcm_cfg_if.sink      cfg
);
    import plcm_pkg::*;

    logic              en;
    logic              s0_valid_reg;
    plcm_item_t        s0_item_reg;
    logic              s1_valid;
    plcm_lk_t          s1_lk;
    logic              s2_valid_reg;
    plcm_div_t         s2_reg;
    plcm_div_t         s2_next;
    logic [DIV_STEPS-1:0] dv_valid_reg;
    plcm_div_t         d_reg [DIV_STEPS];
    logic              out_valid_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic              below_reg;
    logic              above_reg;

    logic [CNT_W-1:0]   entries_reg;
    logic               bounded_reg;
    logic [COLOR_W-1:0] below_color_reg;
    logic [COLOR_W-1:0] above_color_reg;

    // The pipeline advances as a whole unless a finished result is stalled.
    assign en         = !out_valid_reg || result.ready;
    assign item.ready = en;
    assign cfg.ready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg     <= CNT_W'(2);
            bounded_reg     <= 1'b0;
            below_color_reg <= '0;
            above_color_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_ENTRIES: entries_reg     <= cfg.data[CNT_W-1:0];
                CFG_BOUNDED: bounded_reg     <= cfg.data[0];
                CFG_BELOW:   below_color_reg <= cfg.data;
                CFG_ABOVE:   above_color_reg <= cfg.data;
                default:     entries_reg     <= entries_reg;
            endcase
        end
    end

    // Entry register. Values keep their low VALUE_W bits, sign-extended.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg.action       <= action_t'(item.action);
            s0_item_reg.entry_index  <= item.entry_index;
            s0_item_reg.entry_value  <= VALUE_W'(item.entry_value);
            s0_item_reg.entry_color  <= item.entry_color;
            s0_item_reg.sample_value <= VALUE_W'(item.sample_value);
        end
    end

    // Table search: finds the bracketing entries or a direct color.
    plcm_table u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (s0_valid_reg),
        .in_item        (s0_item_reg),
        .entries_in_use (entries_reg),
        .bounded_mode   (bounded_reg),
        .below_color    (below_color_reg),
        .above_color    (above_color_reg),
        .out_valid      (s1_valid),
        .out_lk         (s1_lk)
    );

    // Multiply stage: |cur - prev| times the offset into the segment, per channel.
    always_comb
    begin
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] c;
        logic [CH_W-1:0] mag;
        s2_next.direct = s1_lk.direct;
        s2_next.dcolor = s1_lk.dcolor;
        s2_next.below  = s1_lk.below;
        s2_next.above  = s1_lk.above;
        s2_next.span   = s1_lk.span;
        s2_next.q      = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            p = s1_lk.cp[k*CH_W +: CH_W];
            c = s1_lk.cc[k*CH_W +: CH_W];
            s2_next.p[k]   = p;
            s2_next.neg[k] = c < p;
            mag = (c < p) ? p - c : c - p;
            s2_next.rem[k] = {{VALUE_W{1'b0}}, mag} * {{CH_W{1'b0}}, s1_lk.dv};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_reg <= s2_next;
    end

    // Division stages: the quotient never exceeds 255, so eight steps suffice,
    // most significant bit first.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (en)
                dv_valid_reg[j] <= (j == 0) ? s2_valid_reg : dv_valid_reg[(j == 0) ? 0 : j - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                d_reg[j] <= plcm_div_step((j == 0) ? s2_reg : d_reg[(j == 0) ? 0 : j - 1],
                                          DIV_STEPS - 1 - j);
        end
    end

    // Final stage: floor rounding toward minus infinity for falling channels; direct items take the direct color.
    always_comb
    begin
        plcm_div_t       f;
        logic [CH_W-1:0] q_adj;
        f = d_reg[DIV_STEPS-1];
        color_next = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            q_adj = f.q[k] + CH_W'(f.rem[k] != '0);
            color_next[k*CH_W +: CH_W] = f.neg[k] ? f.p[k] - q_adj : f.p[k] + f.q[k];
        end
        if (f.direct)
            color_next = f.dcolor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_reg <= color_next;
            below_reg <= d_reg[DIV_STEPS-1].below;
            above_reg <= d_reg[DIV_STEPS-1].above;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.color       = color_reg;
    assign result.below_range = below_reg;
    assign result.above_range = above_reg;

endmodule
`default_nettype wire

[hdl/plcm_checker.sv]
`default_nettype none
module plcm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [23:0] color,
    input wire logic        below_range,
    input wire logic        above_range,
    input wire logic        cfg_ready
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(color)
            && $stable(below_range) && $stable(above_range))
        else $error("result changed while stalled");

    // The block refuses requests only while a result is stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("request refused without output stall");

    // A result being taken lets requests in again in the same cycle.
    a_resume: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready |-> item_ready)
        else $error("request blocked while result taken");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind piecewise_linear_color_map plcm_checker u_plcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .color        (result.color),
    .below_range  (result.below_range),
    .above_range  (result.above_range),
    .cfg_ready    (cfg.ready)
);
`default_nettype wire
